### rtl/core/swmf_pkg.sv
package swmf_pkg;

  // Default sizing
  localparam int MAX_WINDOW_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  // Window length register
  localparam int         CFG_LEN_W     = 5;
  localparam logic [4:0] CFG_LEN_RESET = 5'd5;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_DRAIN,
    ST_FINISH
  } swmf_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // latch the accepted item
    logic start_sort;  // clear the sort chain, point at newest sample
    logic read;        // read one window entry into the sort chain
    logic finish;      // store the sample, publish the median if any
  } swmf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic have_result; // window holds at least L samples
    logic rd_last;     // this read is the last of the window
    logic out_busy;    // output register full and not taken this cycle
  } swmf_status_t;

endpackage

### rtl/core/swmf_ram.sv
module swmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/swmf_ctrl.sv
module swmf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  swmf_pkg::swmf_status_t status,
  output swmf_pkg::swmf_cmd_t    cmd
);

  swmf_pkg::swmf_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swmf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      swmf_pkg::ST_IDLE: begin
        if (sample_valid) state_next = swmf_pkg::ST_CHECK;
      end
      swmf_pkg::ST_CHECK: begin
        if (status.have_result) state_next = swmf_pkg::ST_READ;
        else                    state_next = swmf_pkg::ST_FINISH;
      end
      swmf_pkg::ST_READ: begin
        if (status.rd_last) state_next = swmf_pkg::ST_DRAIN;
      end
      swmf_pkg::ST_DRAIN: begin
        state_next = swmf_pkg::ST_FINISH;
      end
      swmf_pkg::ST_FINISH: begin
        // wait while a previous median still occupies the output
        if (!(status.have_result && status.out_busy)) state_next = swmf_pkg::ST_IDLE;
      end
      default: state_next = swmf_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    sample_ready   = 1'b0;
    cmd            = '0;
    unique case (state)
      swmf_pkg::ST_IDLE: begin
        sample_ready = 1'b1;
        cmd.load     = sample_valid;
      end
      swmf_pkg::ST_CHECK: begin
        cmd.start_sort = status.have_result;
      end
      swmf_pkg::ST_READ: begin
        cmd.read = 1'b1;
      end
      swmf_pkg::ST_DRAIN: begin
        cmd = '0;
      end
      swmf_pkg::ST_FINISH: begin
        cmd.finish = !(status.have_result && status.out_busy);
      end
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/core/swmf_datapath.sv
module swmf_datapath #(
  parameter int MAX_WINDOW  = swmf_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [swmf_pkg::CFG_LEN_W-1:0]       cfg_wr_data,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic                                 first_of_signal,
  input  swmf_pkg::swmf_cmd_t                  cmd,
  output swmf_pkg::swmf_status_t               status,
  output logic                                 median_valid,
  input  logic                                 median_ready,
  output logic signed [SAMPLE_BITS-1:0]        median
);

  // Longest odd window that fits
  localparam int LMAX  = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;
  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int CI_W  = $clog2(LMAX);

  logic [swmf_pkg::CFG_LEN_W-1:0] cfg_len;
  logic [swmf_pkg::CFG_LEN_W-1:0] len_odd;
  logic [CNT_W-1:0]               len_eff;
  logic [CNT_W-1:0]               win_len;
  logic [CNT_W-1:0]               fill_count;
  logic [CNT_W-1:0]               rd_cnt;
  logic signed [SAMPLE_BITS-1:0]  sample_hold;
  logic [AW-1:0]                  wr_pos;
  logic [AW-1:0]                  wr_pos_dec;
  logic [AW-1:0]                  rd_ptr;
  logic [AW-1:0]                  rd_ptr_dec;
  logic                           ins_valid;
  logic signed [SAMPLE_BITS-1:0]  rd_data;
  logic signed [SAMPLE_BITS-1:0]  cells [LMAX];
  logic [LMAX-1:0]                cell_valid;
  logic [LMAX-1:0]                gt;
  logic [CI_W-1:0]                mid;

  // Window length register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_len <= swmf_pkg::CFG_LEN_RESET;
    end else if (cfg_wr_en) begin
      cfg_len <= cfg_wr_data;
    end
  end

  // Force odd, clamp to capacity
  assign len_odd = cfg_len | swmf_pkg::CFG_LEN_W'(1);
  always_comb begin
    if (int'(len_odd) > LMAX) len_eff = CNT_W'(LMAX);
    else                      len_eff = CNT_W'(len_odd);
  end

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_hold <= sample;
      win_len     <= len_eff;
    end
  end

  // Fill count: cleared by the start flag, saturates at capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (cmd.load && first_of_signal) begin
      fill_count <= '0;
    end else if (cmd.finish && fill_count != CNT_W'(MAX_WINDOW)) begin
      fill_count <= fill_count + 1'b1;
    end
  end

  // Circular pointers
  assign wr_pos_dec = (wr_pos == '0) ? AW'(MAX_WINDOW - 1) : wr_pos - 1'b1;
  assign rd_ptr_dec = (rd_ptr == '0) ? AW'(MAX_WINDOW - 1) : rd_ptr - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos <= '0;
    end else if (cmd.finish) begin
      wr_pos <= (wr_pos == AW'(MAX_WINDOW - 1)) ? '0 : wr_pos + 1'b1;
    end
  end

  // Read sweep, newest sample first
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt    <= '0;
      ins_valid <= 1'b0;
    end else begin
      ins_valid <= cmd.read;
      if (cmd.start_sort) begin
        rd_cnt <= '0;
      end else if (cmd.read) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_sort) begin
      rd_ptr <= wr_pos_dec;
    end else if (cmd.read) begin
      rd_ptr <= rd_ptr_dec;
    end
  end

  // Sample history
  swmf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.finish),
    .waddr (wr_pos),
    .wdata (sample_hold),
    .raddr (rd_ptr),
    .rdata (rd_data)
  );

  // Sorted cell chain: each read value is inserted in place as it arrives
  genvar i;
  generate
    for (i = 0; i < LMAX; i++) begin : g_cell
      assign gt[i] = !cell_valid[i] || (cells[i] > rd_data);

      if (i == 0) begin : g_head
        always_ff @(posedge clk) begin
          if (rst) begin
            cell_valid[i] <= 1'b0;
          end else if (cmd.start_sort) begin
            cell_valid[i] <= 1'b0;
          end else if (ins_valid && gt[i]) begin
            cell_valid[i] <= 1'b1;
          end
        end
        always_ff @(posedge clk) begin
          if (ins_valid && gt[i]) begin
            cells[i] <= rd_data;
          end
        end
      end else begin : g_body
        always_ff @(posedge clk) begin
          if (rst) begin
            cell_valid[i] <= 1'b0;
          end else if (cmd.start_sort) begin
            cell_valid[i] <= 1'b0;
          end else if (ins_valid && gt[i]) begin
            cell_valid[i] <= gt[i-1] ? cell_valid[i-1] : 1'b1;
          end
        end
        always_ff @(posedge clk) begin
          if (ins_valid && gt[i]) begin
            cells[i] <= gt[i-1] ? cells[i-1] : rd_data;
          end
        end
      end
    end
  endgenerate

  // Output register
  assign mid = CI_W'(win_len >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      median_valid <= 1'b0;
    end else if (cmd.finish && status.have_result) begin
      median_valid <= 1'b1;
    end else if (median_ready) begin
      median_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && status.have_result) begin
      median <= cells[mid];
    end
  end

  // Status to controller
  assign status.have_result = (fill_count >= win_len);
  assign status.rd_last     = (rd_cnt == win_len - 1'b1);
  assign status.out_busy    = median_valid && !median_ready;

endmodule

### rtl/core/sliding_window_median_filter.sv
// Running median over an odd window of L samples (L from the window length register).
// Each item is checked; when it gives a result, each window entry is read from the
// history RAM into the sort chain, the chain is drained and the median published.
// One item is worked on at a time; a median waits while the output is full.
// Reset (rst, synchronous, active high): window length 5, window empty, output empty;
// history RAM contents are not cleared.
module sliding_window_median_filter #(
  parameter int MAX_WINDOW  = swmf_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [swmf_pkg::CFG_LEN_W-1:0] cfg_wr_data,
  input  logic                           sample_valid,
  output logic                           sample_ready,
  input  logic signed [SAMPLE_BITS-1:0]  sample,
  input  logic                           first_of_signal,
  output logic                           median_valid,
  input  logic                           median_ready,
  output logic signed [SAMPLE_BITS-1:0]  median
);

  swmf_pkg::swmf_cmd_t    cmd;
  swmf_pkg::swmf_status_t status;

  // Sequencer
  swmf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // History, sort chain and output register
  swmf_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .sample          (sample),
    .first_of_signal (first_of_signal),
    .cmd             (cmd),
    .status          (status),
    .median_valid    (median_valid),
    .median_ready    (median_ready),
    .median          (median)
  );

endmodule

### rtl/core/swmf_checker.sv
module swmf_checker #(
  parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          sample_valid,
  input logic                          sample_ready,
  input logic                          median_valid,
  input logic                          median_ready,
  input logic signed [SAMPLE_BITS-1:0] median
);

  // A waiting median holds until taken
  a_median_hold: assert property (@(posedge clk) disable iff (rst)
    median_valid && !median_ready |=> median_valid && $stable(median))
    else $error("median changed or dropped while stalled");

  // One item in flight: ready drops after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("item accepted while previous one still in work");

  // No median can be produced in the cycle right after an accept
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !$rose(median_valid))
    else $error("median appeared too early");

  // Reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    rst |=> !median_valid && sample_ready)
    else $error("block not idle after reset");

endmodule

bind sliding_window_median_filter swmf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_swmf_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .median_valid (median_valid),
  .median_ready (median_ready),
  .median       (median)
);

### sim/sliding_window_median_filter_tb.sv
module sliding_window_median_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW    = swmf_pkg::SAMPLE_BITS_DEF;
  localparam int MAXW  = swmf_pkg::MAX_WINDOW_DEF;
  localparam int CFG_W = swmf_pkg::CFG_LEN_W;
  localparam int LMAX  = (MAXW % 2) ? MAXW : MAXW - 1;
  // cycles to let an item that gives no median finish before a register write
  localparam int SETTLE       = LMAX + 12;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int RANDOM_ITEMS = 450;
  localparam int PLAN_ROWS    = 20;

  // one row of the directed plan: either a register write or one item
  typedef struct packed {
    logic              cfg;    // row writes the window length register
    logic [CFG_W-1:0]  len;
    logic signed [SW-1:0] smp;
    logic              sof;
    logic              typed;  // median below is given by hand
    logic signed [SW-1:0] med;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]     cfg_wr_data = '0;
  logic                 sample_valid = 1'b0;
  logic                 sample_ready;
  logic signed [SW-1:0] sample = '0;
  logic                 first_of_signal = 1'b0;
  logic                 median_valid;
  logic                 median_ready = 1'b0;
  logic signed [SW-1:0] median;

  // predictor state
  logic signed [SW-1:0] history [MAXW];
  int unsigned          held_count = 0;
  int unsigned          next_slot = 0;
  logic [CFG_W-1:0]     len_reg = swmf_pkg::CFG_LEN_RESET;

  logic signed [SW-1:0] median_q [$];
  int unsigned          fail_count = 0;
  int unsigned          items_sent = 0;
  int unsigned          medians_seen = 0;
  int unsigned          len_lo = LMAX;
  int unsigned          len_hi = 0;

  // receiver stall state
  int unsigned          stall_left = 0;
  int unsigned          quiet_left = 0;
  int unsigned          roll;
  logic signed [SW-1:0] want;

  plan_row_t plan [PLAN_ROWS] = '{
    // default length 5 after reset: fill with extremes, then read medians
    '{1'b0, 5'd0,  16'sh7fff, 1'b1, 1'b0, 16'sd0},
    '{1'b0, 5'd0, -16'sh8000, 1'b0, 1'b0, 16'sd0},
    '{1'b0, 5'd0,  16'sh7fff, 1'b0, 1'b0, 16'sd0},
    '{1'b0, 5'd0, -16'sh8000, 1'b0, 1'b0, 16'sd0},
    '{1'b0, 5'd0,  16'sd0,    1'b0, 1'b0, 16'sd0},
    '{1'b0, 5'd0,  16'sd100,  1'b0, 1'b1, 16'sd0},
    '{1'b0, 5'd0, -16'sd1,    1'b0, 1'b0, 16'sd0},
    // zero length gives a window of one: median is the previous sample
    '{1'b1, 5'd0,  16'sd0,    1'b0, 1'b0, 16'sd0},
    '{1'b0, 5'd0,  16'sd5,    1'b1, 1'b0, 16'sd0},
    '{1'b0, 5'd0, -16'sd7,    1'b0, 1'b1, 16'sd5},
    '{1'b0, 5'd0,  16'sh7fff, 1'b0, 1'b1, -16'sd7},
    // restart flag: no median for this item
    '{1'b0, 5'd0, -16'sh8000, 1'b1, 1'b0, 16'sd0},
    '{1'b0, 5'd0,  16'sd1,    1'b0, 1'b1, -16'sh8000},
    // length grows mid-signal and applies at once
    '{1'b1, 5'd3,  16'sd0,    1'b0, 1'b0, 16'sd0},
    '{1'b0, 5'd0,  16'sd9,    1'b0, 1'b0, 16'sd0},
    '{1'b0, 5'd0,  16'sd4,    1'b0, 1'b1, 16'sd1},
    // even 30 is raised to 31, then the largest setting
    '{1'b1, 5'd30, 16'sd0,    1'b0, 1'b0, 16'sd0},
    '{1'b0, 5'd0, -16'sd2,    1'b0, 1'b0, 16'sd0},
    '{1'b1, 5'd31, 16'sd0,    1'b0, 1'b0, 16'sd0},
    '{1'b0, 5'd0,  16'sd7,    1'b0, 1'b0, 16'sd0}
  };

  sliding_window_median_filter dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .sample_valid    (sample_valid),
    .sample_ready    (sample_ready),
    .sample          (sample),
    .first_of_signal (first_of_signal),
    .median_valid    (median_valid),
    .median_ready    (median_ready),
    .median          (median)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // effective odd window length for a register value
  function automatic int unsigned window_len(logic [CFG_W-1:0] r);
    int unsigned l;
    l = 32'(r);
    if (l % 2 == 0) l++;
    if (l > LMAX) l = LMAX;
    return l;
  endfunction

  // take one sample into the history; returns 1 with the median when one is due
  function automatic bit window_median(input logic signed [SW-1:0] s, input logic sof,
                                       output logic signed [SW-1:0] med);
    logic signed [SW-1:0] sorted [MAXW];
    logic signed [SW-1:0] v;
    int unsigned len;
    int unsigned pos;
    int unsigned j;
    bit due;
    len = window_len(len_reg);
    if (sof) held_count = 0;
    due = (held_count >= len);
    med = '0;
    if (due) begin
      // walk back from the newest entry, insertion sort as we go
      pos = next_slot;
      for (int unsigned i = 0; i < len; i++) begin
        pos = (pos + MAXW - 1) % MAXW;
        v = history[pos];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      med = sorted[len / 2];
    end
    history[next_slot] = s;
    next_slot = (next_slot + 1) % MAXW;
    if (held_count < MAXW) held_count++;
    return due;
  endfunction

  // mostly back to back, sometimes a short gap, rarely a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // full range, a narrow band for ties, and the extremes
  function automatic logic signed [SW-1:0] pick_sample();
    logic signed [SW-1:0] s;
    case ($urandom_range(0, 9))
      5, 6:    s = SW'($signed($urandom_range(0, 16)) - 8);
      7:       s = $urandom_range(0, 1) ? {1'b0, {(SW-1){1'b1}}} : {1'b1, {(SW-1){1'b0}}};
      8:       s = $urandom_range(0, 1)
                   ? {1'b0, {(SW-1){1'b1}}} - SW'($urandom_range(0, 3))
                   : {1'b1, {(SW-1){1'b0}}} + SW'($urandom_range(0, 3));
      default: s = SW'($urandom);
    endcase
    return s;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // send one item, then record the median it should cause
  task automatic push_sample(input logic signed [SW-1:0] s, input logic sof,
                             input int unsigned gap, input logic typed,
                             input logic signed [SW-1:0] typed_med);
    logic signed [SW-1:0] med;
    bit due;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid    <= 1'b1;
    sample          <= s;
    first_of_signal <= sof;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    items_sent++;
    due = window_median(s, sof, med);
    if (typed) median_q.push_back(typed_med);
    else if (due) median_q.push_back(med);
  endtask

  // wait for every pending median, bounded
  task automatic wait_drained();
    int unsigned n;
    n = 0;
    while (median_q.size() > 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // register writes only once the block has gone quiet
  task automatic write_window_length(input logic [CFG_W-1:0] v);
    sample_valid <= 1'b0;
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    len_reg = v;
    if (window_len(v) < len_lo) len_lo = window_len(v);
    if (window_len(v) > len_hi) len_hi = window_len(v);
  endtask

  // result side: random stalls, with calm stretches
  always @(posedge clk) begin
    if (rst) begin
      median_ready <= 1'b0;
    end else if (stall_left > 0) begin
      median_ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (quiet_left > 0) begin
      median_ready <= 1'b1;
      quiet_left   <= quiet_left - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        median_ready <= 1'b1;
      end else if (roll < 75) begin
        median_ready <= 1'b1;
        quiet_left   <= $urandom_range(40, 150);
      end else if (roll < 95) begin
        median_ready <= 1'b0;
        stall_left   <= $urandom_range(0, 2);
      end else begin
        median_ready <= 1'b0;
        stall_left   <= $urandom_range(8, 30);
      end
    end
  end

  // compare each median taken against the oldest one predicted
  always @(posedge clk) begin
    if (!rst && median_valid && median_ready) begin
      medians_seen++;
      if (median_q.size() == 0) begin
        note_failure($sformatf("median %0d with none expected", median));
      end else begin
        want = median_q.pop_front();
        if (median !== want)
          note_failure($sformatf("median: expected %0d, got %0d", want, median));
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned          rand_sent;
    int unsigned          n;
    logic [CFG_W-1:0]     len_req;
    logic                 sof;
    bit                   steady;
    rand_sent = 0;
    foreach (history[i]) history[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed plan
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].cfg)
        write_window_length(plan[i].len);
      else
        push_sample(plan[i].smp, plan[i].sof, idle_len(), plan[i].typed, plan[i].med);
    end

    // random signals, each phase under its own window length
    while (rand_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       len_req = '0;
        1:       len_req = {CFG_W{1'b1}};
        2:       len_req = {{(CFG_W-1){1'b1}}, 1'b0};
        3:       len_req = CFG_W'(1);
        default: len_req = CFG_W'($urandom_range(2, 12));
      endcase
      write_window_length(len_req);
      steady = ($urandom_range(0, 3) == 0);
      n = window_len(len_req) + $urandom_range(10, 40);
      for (int unsigned k = 0; k < n && rand_sent < RANDOM_ITEMS; k++) begin
        // a phase may restart the signal or carry on with the old history
        if (k == 0) sof = $urandom_range(0, 1);
        else        sof = ($urandom_range(0, 29) == 0);
        push_sample(pick_sample(), sof, steady ? 0 : idle_len(), 1'b0, '0);
        rand_sent++;
      end
    end

    sample_valid <= 1'b0;
    wait_drained();
    if (median_q.size() != 0)
      note_failure($sformatf("%0d medians never arrived", median_q.size()));

    $display("Sent %0d samples with window lengths %0d to %0d; %0d medians checked.",
             items_sent, len_lo, len_hi, medians_seen);
    $display("Failures: %0d", fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
